// ----- sv/md5bc_pkg.sv -----
// md5bc_pkg: types, constants and tables shared by the MD5 block compression engine.
// Holds the microcode ROM, round constants and rotation table.
// No dependencies.
package md5bc_pkg;

  // standard chaining value after reset or a new message
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned BLOCK_WORDS = 16;

  typedef logic [5:0]  round_idx_t;
  typedef logic [3:0]  word_idx_t;
  typedef logic [31:0] word_t;

  // round groups (top two bits of the round number)
  localparam logic [1:0] GRP_F = 2'd0;
  localparam logic [1:0] GRP_G = 2'd1;
  localparam logic [1:0] GRP_H = 2'd2;
  localparam logic [1:0] GRP_I = 2'd3;

  localparam word_t ROUND_K [NUM_ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // indexed by {group, round[1:0]}
  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word used by a round
  function automatic word_idx_t msg_index(input round_idx_t rnd);
    word_idx_t low;
    word_idx_t idx;
    low = rnd[3:0];
    case (rnd[5:4])
      GRP_F:   idx = low;
      GRP_G:   idx = low * 4'd5 + 4'd1;
      GRP_H:   idx = low * 4'd3 + 4'd5;
      GRP_I:   idx = low * 4'd7;
      default: idx = low;
    endcase
    return idx;
  endfunction

  // ---- microcode ----
  typedef logic [1:0] upc_t;

  typedef enum logic [1:0] {
    UOP_COLLECT,   // take message words into the buffer
    UOP_PREFETCH,  // load working words, read first message word
    UOP_ROUND,     // one MD5 round
    UOP_FINISH     // fold into chaining value, present result
  } uop_t;

  typedef enum logic [1:0] {
    UC_NEVER,        // always fall through
    UC_BLOCK_OPEN,   // block not yet complete this cycle
    UC_ROUNDS_LEFT,  // more rounds to run
    UC_OUT_BUSY      // result register still occupied
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;    // jump to target when true, else next step
    upc_t   target;
  } uword_t;

  localparam int unsigned UCODE_DEPTH = 4;

  localparam uword_t UCODE [UCODE_DEPTH] = '{
    '{op: UOP_COLLECT,  cond: UC_BLOCK_OPEN,  target: 2'd0},
    '{op: UOP_PREFETCH, cond: UC_NEVER,       target: 2'd0},
    '{op: UOP_ROUND,    cond: UC_ROUNDS_LEFT, target: 2'd2},
    '{op: UOP_FINISH,   cond: UC_OUT_BUSY,    target: 2'd3}
  };

endpackage

// ----- sv/md5bc_if.sv -----
// md5bc_if: valid/ready channel interfaces for the MD5 block compression engine.
// Message word input channel and chaining value result channel.
// No dependencies.
interface md5bc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic        new_message;

  modport source(output valid, message_word, new_message, input ready);
  modport sink(input valid, message_word, new_message, output ready);
endinterface

interface md5bc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_a;
  logic [31:0] hash_b;
  logic [31:0] hash_c;
  logic [31:0] hash_d;

  modport source(output valid, hash_a, hash_b, hash_c, hash_d, input ready);
  modport sink(input valid, hash_a, hash_b, hash_c, hash_d, output ready);
endinterface

// ----- sv/md5_block_compression.sv -----
// md5_block_compression: MD5 compression engine, microcoded sequencer top level.
// Depends on md5bc_pkg and the channel interfaces in md5bc_if.
//
// Takes one 32-bit message word per input beat, word 0 of a block first; a
// beat with new_message set reloads the standard initial chaining value and
// starts a fresh block at word 0 (a partial block is dropped). Words are taken
// one per cycle while the block collects; after the sixteenth word the input
// stalls while the block runs its steps in order: a step that loads the working
// words and reads the first message word, 64 rounds at one round per cycle on
// a single round unit fed from the one-read-port word buffer, and a step that
// folds the result into the chaining value. The finishing step waits while an
// earlier result is still in the output register. Each full block gives one
// result beat carrying the four chaining words.
module md5_block_compression (
  input  logic         clk,
  input  logic         rst_n,
  md5bc_in_if.sink     in_ch,
  md5bc_out_if.source  out_ch
);

  // ---- sequencer ----
  md5bc_pkg::upc_t   pc_r, pc_nxt;
  md5bc_pkg::uword_t uw;
  logic              cond_hit;

  // ---- collection ----
  md5bc_pkg::word_idx_t cnt_r, cnt_nxt;
  md5bc_pkg::word_idx_t wr_idx;
  logic                 in_beat;

  // ---- word buffer (one write, one registered read) ----
  md5bc_pkg::word_t     buf_mem [md5bc_pkg::BLOCK_WORDS];
  md5bc_pkg::word_t     mem_rd_r;
  md5bc_pkg::word_idx_t rd_addr;

  // ---- round datapath ----
  md5bc_pkg::word_t       cv_r [4];
  md5bc_pkg::word_t       cv_nxt [4];
  md5bc_pkg::word_t       a_r, b_r, c_r, d_r;
  md5bc_pkg::round_idx_t  rnd_r;
  md5bc_pkg::round_idx_t  rnd_inc;
  md5bc_pkg::word_t       f_val, sum, rot;
  logic [63:0]            rot_dbl;
  logic [4:0]             rot_amt;

  // ---- result register ----
  logic             out_valid_r, out_valid_nxt;
  md5bc_pkg::word_t hash_r [4];
  logic             out_free;

  assign uw       = md5bc_pkg::UCODE[pc_r];
  assign in_ch.ready = (uw.op == md5bc_pkg::UOP_COLLECT);
  assign in_beat  = in_ch.valid && in_ch.ready;
  // new message restarts at word 0 regardless of the count
  assign wr_idx   = in_ch.new_message ? '0 : cnt_r;
  assign out_free = !out_valid_r || out_ch.ready;
  assign rnd_inc  = md5bc_pkg::round_idx_t'(rnd_r + 1'b1);

  // step sequencing: conditional jump or fall through
  always_comb begin
    case (uw.cond)
      md5bc_pkg::UC_NEVER:       cond_hit = 1'b0;
      md5bc_pkg::UC_BLOCK_OPEN:  cond_hit = !(in_beat && (wr_idx == 4'd15));
      md5bc_pkg::UC_ROUNDS_LEFT: cond_hit = (rnd_r != 6'd63);
      md5bc_pkg::UC_OUT_BUSY:    cond_hit = !out_free;
      default:                   cond_hit = 1'b0;
    endcase
    pc_nxt = cond_hit ? uw.target : md5bc_pkg::upc_t'(pc_r + 1'b1);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_beat) begin
      cnt_nxt = md5bc_pkg::word_idx_t'(wr_idx + 1'b1);   // wraps to 0 after word 15
    end
  end

  // read address runs one round ahead of the datapath
  always_comb begin
    if (uw.op == md5bc_pkg::UOP_PREFETCH) begin
      rd_addr = md5bc_pkg::msg_index('0);
    end else begin
      rd_addr = md5bc_pkg::msg_index(rnd_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      buf_mem[wr_idx] <= in_ch.message_word;
    end
    mem_rd_r <= buf_mem[rd_addr];
  end

  // one MD5 round
  always_comb begin
    case (rnd_r[5:4])
      md5bc_pkg::GRP_F: f_val = d_r ^ (b_r & (c_r ^ d_r));
      md5bc_pkg::GRP_G: f_val = c_r ^ (d_r & (b_r ^ c_r));
      md5bc_pkg::GRP_H: f_val = b_r ^ c_r ^ d_r;
      md5bc_pkg::GRP_I: f_val = c_r ^ (b_r | ~d_r);
      default:          f_val = '0;
    endcase
    sum     = a_r + f_val + mem_rd_r + md5bc_pkg::ROUND_K[rnd_r];
    rot_amt = md5bc_pkg::ROT_AMT[{rnd_r[5:4], rnd_r[1:0]}];
    rot_dbl = {sum, sum} << rot_amt;
    rot     = rot_dbl[63:32];
  end

  // chaining value: reload on a new message, fold at the end of a block
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cv_nxt[i] = cv_r[i];
    end
    if (in_beat && in_ch.new_message) begin
      cv_nxt[0] = md5bc_pkg::IV_A;
      cv_nxt[1] = md5bc_pkg::IV_B;
      cv_nxt[2] = md5bc_pkg::IV_C;
      cv_nxt[3] = md5bc_pkg::IV_D;
    end else if (uw.op == md5bc_pkg::UOP_FINISH && out_free) begin
      cv_nxt[0] = cv_r[0] + a_r;
      cv_nxt[1] = cv_r[1] + b_r;
      cv_nxt[2] = cv_r[2] + c_r;
      cv_nxt[3] = cv_r[3] + d_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (uw.op == md5bc_pkg::UOP_FINISH && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state and chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      cv_r[0]     <= md5bc_pkg::IV_A;
      cv_r[1]     <= md5bc_pkg::IV_B;
      cv_r[2]     <= md5bc_pkg::IV_C;
      cv_r[3]     <= md5bc_pkg::IV_D;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 4; i++) begin
        cv_r[i] <= cv_nxt[i];
      end
    end
  end

  // working words, round counter, result payload
  always_ff @(posedge clk) begin
    case (uw.op)
      md5bc_pkg::UOP_PREFETCH: begin
        a_r   <= cv_r[0];
        b_r   <= cv_r[1];
        c_r   <= cv_r[2];
        d_r   <= cv_r[3];
        rnd_r <= '0;
      end
      md5bc_pkg::UOP_ROUND: begin
        a_r   <= d_r;
        b_r   <= b_r + rot;
        c_r   <= b_r;
        d_r   <= c_r;
        rnd_r <= rnd_inc;
      end
      md5bc_pkg::UOP_FINISH: begin
        if (out_free) begin
          for (int i = 0; i < 4; i++) begin
            hash_r[i] <= cv_nxt[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.hash_a = hash_r[0];
  assign out_ch.hash_b = hash_r[1];
  assign out_ch.hash_c = hash_r[2];
  assign out_ch.hash_d = hash_r[3];

endmodule

// ----- sv/md5bc_checker.sv -----
// md5bc_checker: port-level assertions for md5_block_compression, with its bind.
// Depends on md5_block_compression and the channel interfaces in md5bc_if.
module md5bc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [127:0] out_payload
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // and keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_payload))
    else $error("result payload changed while stalled");

  // input only closes after taking the last word of a block
  a_close_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input closed without a word beat");

  // a new result only appears while the input is closed
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised while collecting words");

endmodule

bind md5_block_compression md5bc_checker u_md5bc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload ({out_ch.hash_a, out_ch.hash_b, out_ch.hash_c, out_ch.hash_d})
);

// ----- verif/tb_top.sv -----
// tb_top: self-checking testbench for md5_block_compression.
// Needs md5bc_pkg, the channel interfaces in md5bc_if and the block itself.
// Includes its own MD5 compression predictor and random valid/ready stalls.
module tb_top;

  // Predictor constants, kept apart from the package tables so that a slip in
  // those tables cannot hide itself.
  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotation per {round group, round mod 4}
  localparam int unsigned SHIFT_AMT [16] = '{
    7, 12, 17, 22,  5, 9, 14, 20,  4, 11, 16, 23,  6, 10, 15, 21
  };

  // Watchdog bound, set with a wide margin over the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned CALM_TAIL   = 100;   // last beats sent with no stalls
  localparam int unsigned DRAIN_WAIT  = 150;   // longer than one block's crunch
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct {
    logic [31:0] word;
    logic        first;   // new_message flag
  } msg_beat_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  logic clk;
  logic rst_n;

  md5bc_in_if  in_if ();
  md5bc_out_if out_if ();

  md5_block_compression u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // ---------------------------------------------------------------------------
  // Stimulus store and predictor state
  // ---------------------------------------------------------------------------
  msg_beat_t   beat_q [$];        // word beats still to send
  digest_t     digest_q [$];      // chaining values still to come out
  int unsigned beats_total;
  int unsigned beats_taken;
  int unsigned bad_count;
  int unsigned cycle_count;
  bit          calm;              // tail of the run: no stalls on either side

  digest_t     chain_cv;          // predicted chaining value
  logic [31:0] blk_words [16];    // predicted word buffer
  int unsigned fill_cnt;          // words held in the current block

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned s);
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  // 64 rounds over the buffered block, folded into the chaining value
  function automatic digest_t md5_fold(input digest_t cv);
    logic [31:0] a, b, c, d, f, t;
    int unsigned g;
    a = cv.a;
    b = cv.b;
    c = cv.c;
    d = cv.d;
    for (int unsigned r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = d ^ (b & (c ^ d));
          g = r;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = a + f + blk_words[g] + SINE_K[r];
      t = b + rotl32(t, SHIFT_AMT[(r / 16) * 4 + r % 4]);
      a = d;
      d = c;
      c = b;
      b = t;
    end
    cv.a = cv.a + a;
    cv.b = cv.b + b;
    cv.c = cv.c + c;
    cv.d = cv.d + d;
    return cv;
  endfunction

  // Predictor step for one accepted word beat.
  task automatic take_word(input msg_beat_t bt);
    if (bt.first) begin
      // new message: fresh initial value, any partial block is thrown away
      chain_cv = '{H0_INIT, H1_INIT, H2_INIT, H3_INIT};
      fill_cnt = 0;
    end
    blk_words[fill_cnt] = bt.word;
    if (fill_cnt == 15) begin
      fill_cnt = 0;
      chain_cv = md5_fold(chain_cv);
      digest_q.push_back(chain_cv);
    end else begin
      fill_cnt++;
    end
  endtask

  task automatic queue_word(input logic [31:0] w, input logic f);
    msg_beat_t bt;
    bt.word  = w;
    bt.first = f;
    beat_q.push_back(bt);
  endtask

  // mostly full-entropy words, now and then an extreme
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_block(input logic lead_flag);
    for (int i = 0; i < 16; i++)
      queue_word(pick_word(), (i == 0) ? lead_flag : 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and stimulus build
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    int unsigned kind;
    int unsigned n;

    // known levels on every block input before the first edge
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.message_word  = '0;
    in_if.new_message   = 1'b0;
    out_if.ready        = 1'b0;

    // Directed: two words straight out of reset with no flag, then a flag in
    // the middle of that block restarts it; the fresh block mixes the word
    // extremes so the adders wrap and the boolean functions see all-ones.
    queue_word(32'hffff_ffff, 1'b0);
    queue_word(32'h0000_0000, 1'b0);
    queue_word(32'h0000_0000, 1'b1);
    for (int i = 1; i < 16; i++) begin
      case (i % 4)
        0: queue_word(32'h0000_0000, 1'b0);
        1: queue_word(32'hffff_ffff, 1'b0);
        2: queue_word(32'h8000_0000, 1'b0);
        default: queue_word(32'h0000_0001, 1'b0);
      endcase
    end

    // Random: mainly whole messages of one to three blocks, with some bare
    // continuation blocks (chained on whatever went before), broken partial
    // blocks that the next flag drops, and beats with the flag set at random.
    while (beat_q.size() < 668) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        n = $urandom_range(1, 3);
        for (int blk = 0; blk < n; blk++)
          queue_block(blk == 0);
      end else if (kind == 6) begin
        queue_block(1'b0);
      end else if (kind <= 8) begin
        n = $urandom_range(1, 15);
        for (int i = 0; i < n; i++)
          queue_word(pick_word(), (i == 0));
      end else begin
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
          queue_word($urandom(), ($urandom_range(0, 3) == 0));
      end
    end
    beats_total = beat_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // drain: every beat taken, every digest seen, then a quiet spell in which
    // a spurious result beat would still be caught by the monitor
    while (beats_taken != beats_total) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (bad_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: one word beat per handshake, with random gaps of idle cycles
  // ---------------------------------------------------------------------------
  int unsigned in_gap;
  msg_beat_t   next_beat;

  initial begin
    beats_taken = 0;
    in_gap      = 0;
    chain_cv    = '{H0_INIT, H1_INIT, H2_INIT, H3_INIT};
    fill_cnt    = 0;
    foreach (blk_words[i]) blk_words[i] = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      // beat taken at this edge: feed the predictor with what was on the bus
      if (in_if.valid && in_if.ready) begin
        next_beat.word  = in_if.message_word;
        next_beat.first = in_if.new_message;
        take_word(next_beat);
        beats_taken++;
      end
      calm = (beat_q.size() < CALM_TAIL);
      if (!in_if.valid || in_if.ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (beat_q.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 2);
          in_if.valid <= 1'b0;
        end else begin
          next_beat = beat_q.pop_front();
          in_if.valid        <= 1'b1;
          in_if.message_word <= next_beat.word;
          in_if.new_message  <= next_beat.first;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each digest beat against the oldest prediction
  // ---------------------------------------------------------------------------
  int unsigned out_gap;
  digest_t     seen_dg;
  digest_t     want_dg;

  initial begin
    bad_count = 0;
    out_gap   = 0;
  end

  task automatic flag_field(input string fld, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      bad_count++;
      if (bad_count <= REPORT_MAX)
        $display("[%0d] digest %s mismatch: expected %08h got %08h",
                 cycle_count, fld, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        seen_dg = '{out_if.hash_a, out_if.hash_b, out_if.hash_c, out_if.hash_d};
        if (digest_q.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_MAX)
            $display("[%0d] unexpected digest beat %08h %08h %08h %08h", cycle_count,
                     seen_dg.a, seen_dg.b, seen_dg.c, seen_dg.d);
        end else begin
          want_dg = digest_q.pop_front();
          flag_field("a", want_dg.a, seen_dg.a);
          flag_field("b", want_dg.b, seen_dg.b);
          flag_field("c", want_dg.c, seen_dg.c);
          flag_field("d", want_dg.d, seen_dg.d);
        end
      end
      // back-pressure in short bursts, none in the tail
      if (out_gap != 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
